// ===== hw/rtl/lwrs_pkg.sv =====
// lwrs_pkg: shared widths, types and arithmetic helpers for the span splitter
// used by every module under hw/rtl; depends on nothing
package lwrs_pkg;

  localparam int unsigned MAX_PIXELS      = 4194304;
  localparam int unsigned MAX_WIDTH       = 4096;
  localparam int unsigned BYTES_PER_PIXEL = 4;

  localparam int unsigned BYTE_W = 24;
  localparam int unsigned PIX_W  = $clog2(MAX_PIXELS);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W  = COL_W + 1;
  localparam int unsigned SUB_W  = $clog2(BYTES_PER_PIXEL);

  // divider pipeline: quotient bits resolved per stage
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = (PIX_W + DIV_BITS - 1) / DIV_BITS;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 96;

  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(400);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [WID_W-1:0] width_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ERR,
    KIND_OK
  } kind_e;

  // one slot of the divider pipeline, two divisions side by side
  typedef struct packed {
    logic  valid;
    kind_e kind;
    pix_t  n;
    pix_t  a_num;
    col_t  a_rem;
    pix_t  b_num;
    col_t  b_rem;
  } div_stage_t;

  // classified write, handed from front to back
  typedef struct packed {
    kind_e  kind;
    logic   single;
    col_t   x1;
    pix_t   y1;
    pix_t   y2;
    pix_t   n;
    width_t first_w;
    pix_t   mid_h;
    pix_t   src_c;
  } cmd_entry_t;

  // rectangle command, rect_x in the lowest bits
  typedef struct packed {
    pix_t   source_pixel;
    pix_t   rect_h;
    width_t rect_w;
    pix_t   rect_y;
    col_t   rect_x;
  } rect_t;

  typedef struct packed {
    col_t rem;
    pix_t num;
  } div_res_t;

  // one restoring division step: next dividend bit enters the remainder
  function automatic div_res_t div_step(col_t rem, pix_t num, width_t d);
    logic [WID_W-1:0] t;
    logic [WID_W-1:0] diff;
    div_res_t         r;
    t = {rem, num[PIX_W-1]};
    diff = t - d;
    if (t >= d) begin
      r.rem = diff[COL_W-1:0];
      r.num = {num[PIX_W-2:0], 1'b1};
    end else begin
      r.rem = t[COL_W-1:0];
      r.num = {num[PIX_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // zero width reads as one, wide values saturate
  function automatic width_t clamp_width(width_t v);
    width_t r;
    if (v == '0) begin
      r = width_t'(1);
    end else if (v > width_t'(MAX_WIDTH)) begin
      r = width_t'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lwrs_front.sv =====
// lwrs_front: accepts writes, checks them and finds start/end row and column
// through a pipelined divider; depends on lwrs_pkg
module lwrs_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lwrs_pkg::BYTE_W-1:0]  byte_offset_i,
  input  logic [lwrs_pkg::BYTE_W-1:0]  byte_length_i,
  input  lwrs_pkg::width_t             width_i,
  output logic                         out_valid_o,
  output lwrs_pkg::cmd_entry_t         out_entry_o,
  input  logic                         out_ready_i
);
  import lwrs_pkg::*;

  logic       en;
  div_stage_t st_q [DIV_STAGES+1];
  div_stage_t st0_d;
  logic [PIX_W:0] sum;
  logic [PIX_W:0] p1_full;
  pix_t       p0;
  pix_t       n;

  logic       p1_v_q, p2_v_q, p3_v_q;
  cmd_entry_t p1_q, p2_q, p3_q;
  cmd_entry_t p1_d, p3_d;
  pix_t       mid_w_q;
  logic [PIX_W+WID_W-1:0] prod;
  logic [PIX_W:0] src_sum;

  // whole pipe advances unless the last slot holds an entry the queue refuses
  assign en          = !(p3_v_q && (p3_q.kind != KIND_NONE)) || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = p3_v_q && (p3_q.kind != KIND_NONE);
  assign out_entry_o = p3_q;

  // decode and classify the incoming write
  always_comb begin
    p0      = byte_offset_i[BYTE_W-1:SUB_W];
    n       = byte_length_i[BYTE_W-1:SUB_W];
    sum     = {1'b0, p0} + {1'b0, n};
    p1_full = sum - (PIX_W+1)'(1);
    st0_d.valid = in_valid_i;
    st0_d.n     = n;
    st0_d.a_num = p0;
    st0_d.a_rem = '0;
    st0_d.b_num = p1_full[PIX_W-1:0];
    st0_d.b_rem = '0;
    if (byte_length_i == '0) begin
      st0_d.kind = KIND_NONE;
    end else if ((byte_offset_i[SUB_W-1:0] != '0) || (byte_length_i[SUB_W-1:0] != '0)) begin
      st0_d.kind = KIND_ERR;
    end else if (sum > (PIX_W+1)'(MAX_PIXELS)) begin
      st0_d.kind = KIND_ERR;
    end else begin
      st0_d.kind = KIND_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else if (en) begin
      st_q[0] <= st0_d;
    end
  end

  // divider stages: start pixel and last pixel divided by the row width
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_stage_t nxt;
    div_res_t   ra, rb;

    always_comb begin
      nxt = st_q[g];
      ra  = '{rem: st_q[g].a_rem, num: st_q[g].a_num};
      rb  = '{rem: st_q[g].b_rem, num: st_q[g].b_num};
      for (int unsigned k = 0; k < DIV_BITS; k++) begin
        ra = div_step(ra.rem, ra.num, width_i);
        rb = div_step(rb.rem, rb.num, width_i);
      end
      nxt.a_rem = ra.rem;
      nxt.a_num = ra.num;
      nxt.b_rem = rb.rem;
      nxt.b_num = rb.num;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[g+1] <= '0;
      end else if (en) begin
        st_q[g+1] <= nxt;
      end
    end
  end

  // first row width and count of full middle rows
  always_comb begin
    p1_d.kind    = st_q[DIV_STAGES].kind;
    p1_d.x1      = st_q[DIV_STAGES].a_rem;
    p1_d.y1      = st_q[DIV_STAGES].a_num;
    p1_d.y2      = st_q[DIV_STAGES].b_num;
    p1_d.n       = st_q[DIV_STAGES].n;
    p1_d.single  = (st_q[DIV_STAGES].a_num == st_q[DIV_STAGES].b_num);
    p1_d.first_w = width_i - {1'b0, st_q[DIV_STAGES].a_rem};
    p1_d.mid_h   = st_q[DIV_STAGES].b_num - st_q[DIV_STAGES].a_num - pix_t'(1);
    p1_d.src_c   = '0;
  end

  // middle rows in pixels, then source offset of the last row
  assign prod    = p1_q.mid_h * width_i;
  assign src_sum = {{(PIX_W+1-WID_W){1'b0}}, p2_q.first_w} + {1'b0, mid_w_q};

  always_comb begin
    p3_d       = p2_q;
    p3_d.src_c = src_sum[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p1_q    <= '0;
      p2_q    <= '0;
      p3_q    <= '0;
      mid_w_q <= '0;
    end else if (en) begin
      p1_v_q  <= st_q[DIV_STAGES].valid;
      p1_q    <= p1_d;
      p2_v_q  <= p1_v_q;
      p2_q    <= p1_q;
      mid_w_q <= prod[PIX_W-1:0];
      p3_v_q  <= p2_v_q;
      p3_q    <= p3_d;
    end
  end

endmodule

// ===== hw/rtl/lwrs_queue.sv =====
// lwrs_queue: short first-in first-out queue of classified writes
// between front and back; depends on lwrs_pkg
module lwrs_queue #(
  parameter int unsigned DEPTH = lwrs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lwrs_pkg::cmd_entry_t entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output lwrs_pkg::cmd_entry_t entry_o
);
  import lwrs_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_entry_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lwrs_back.sv =====
// lwrs_back: expands one classified write into its rectangle commands,
// one per cycle while the output is not stalled, into the output register; depends on lwrs_pkg
module lwrs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  lwrs_pkg::cmd_entry_t q_entry_i,
  output logic                 pop_o,
  input  lwrs_pkg::width_t     width_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lwrs_pkg::rect_t      out_rect_o,
  output logic                 out_error_o,
  output logic                 out_last_o
);
  import lwrs_pkg::*;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_MID,
    PH_LAST
  } phase_e;

  phase_e phase_q, phase_d;
  logic   out_valid_q;
  rect_t  rect_q, rect_d;
  logic   error_q, error_d;
  logic   last_q, last_d;
  logic   done, load;
  pix_t   last_w;

  assign last_w = q_entry_i.n - q_entry_i.src_c;

  // pick the command for the head entry and current phase
  always_comb begin
    rect_d  = '0;
    error_d = 1'b0;
    last_d  = 1'b0;
    done    = 1'b0;
    phase_d = phase_q;
    if (q_entry_i.kind == KIND_ERR) begin
      error_d = 1'b1;
      last_d  = 1'b1;
      done    = 1'b1;
    end else if (q_entry_i.single) begin
      rect_d.rect_x = q_entry_i.x1;
      rect_d.rect_y = q_entry_i.y1;
      rect_d.rect_w = q_entry_i.n[WID_W-1:0];
      rect_d.rect_h = pix_t'(1);
      last_d        = 1'b1;
      done          = 1'b1;
    end else begin
      case (phase_q)
        PH_FIRST: begin
          rect_d.rect_x = q_entry_i.x1;
          rect_d.rect_y = q_entry_i.y1;
          rect_d.rect_w = q_entry_i.first_w;
          rect_d.rect_h = pix_t'(1);
          phase_d       = (q_entry_i.mid_h != '0) ? PH_MID : PH_LAST;
        end
        PH_MID: begin
          rect_d.rect_y       = q_entry_i.y1 + pix_t'(1);
          rect_d.rect_w       = width_i;
          rect_d.rect_h       = q_entry_i.mid_h;
          rect_d.source_pixel = {{(PIX_W-WID_W){1'b0}}, q_entry_i.first_w};
          phase_d             = PH_LAST;
        end
        PH_LAST: begin
          rect_d.rect_y       = q_entry_i.y2;
          rect_d.rect_w       = last_w[WID_W-1:0];
          rect_d.rect_h       = pix_t'(1);
          rect_d.source_pixel = q_entry_i.src_c;
          last_d              = 1'b1;
          done                = 1'b1;
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase
    end
    if (done) begin
      phase_d = PH_FIRST;
    end
  end

  assign load  = q_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && done;

  // phase and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
      rect_q      <= '0;
      error_q     <= 1'b0;
      last_q      <= 1'b0;
    end else if (load) begin
      phase_q     <= phase_d;
      out_valid_q <= 1'b1;
      rect_q      <= rect_d;
      error_q     <= error_d;
      last_q      <= last_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rect_o  = rect_q;
  assign out_error_o = error_q;
  assign out_last_o  = last_q;

endmodule

// ===== hw/rtl/linear_write_to_rect_splitter.sv =====
// linear_write_to_rect_splitter: top level of the span splitter
// depends on lwrs_pkg, lwrs_front, lwrs_queue and lwrs_back
//
// Usage:
//   s_axis carries one framebuffer write (byte offset, byte length, 4 bytes
//   per pixel). m_axis returns up to three rectangle commands per write:
//   partial first row, full middle rows, partial last row; tlast marks the
//   final command of a write, tuser flags an error command (misaligned or
//   past the framebuffer). A zero-length write gives no command.
//   cfg sets the screen width in pixels; it is always ready. The user must
//   see that it is written only while the block is idle; the block itself
//   does not enforce this. Zero reads as one, widths above 4096 saturate.
//   Stages: classify, the 11-stage divider (two quotient bits per stage),
//   first row, multiply, add, queue and output register.
//   Throughput: one write per cycle enters the front while it is not stalled;
//   the back emits one command per cycle while the output is not stalled.
//   Reset: pipe, queue and output are empty, screen width returns to 400.
//   Output stall: the output register holds; the queue absorbs writes until
//   full, then the whole front pipe stalls and s_axis_tready_o drops.
module linear_write_to_rect_splitter #(
  parameter int unsigned QDEPTH = lwrs_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // byte_offset [23:0], byte_length [47:24]
  input  logic [lwrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // rect_x [11:0], rect_y [33:12], rect_w [46:34], rect_h [68:47],
  // source_pixel [90:69], zero fill above
  output logic [lwrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // error [0]
  output logic [0:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  lwrs_pkg::width_t                 cfg_data_i
);
  import lwrs_pkg::*;

  localparam int unsigned PAD_W = OUT_TDATA_W - $bits(rect_t);

  width_t     width_q;
  logic       f_valid, q_full, q_valid, q_pop;
  cmd_entry_t f_entry, q_entry;
  rect_t      rect;
  logic       rect_error;

  // screen width register, stored already clamped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= clamp_width(cfg_data_i);
    end
  end

  // classify and divide
  lwrs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .byte_offset_i (s_axis_tdata_i[BYTE_W-1:0]),
    .byte_length_i (s_axis_tdata_i[2*BYTE_W-1:BYTE_W]),
    .width_i       (width_q),
    .out_valid_o   (f_valid),
    .out_entry_o   (f_entry),
    .out_ready_i   (!q_full)
  );

  // decoupling queue
  lwrs_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // command emission
  lwrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (q_pop),
    .width_i     (width_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rect_o  (rect),
    .out_error_o (rect_error),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, rect};
  assign m_axis_tuser_o = rect_error;

endmodule

// ===== hw/rtl/lwrs_checker.sv =====
// lwrs_checker: port-level checks on the span splitter output stream
// depends on lwrs_pkg; bound to linear_write_to_rect_splitter below
module lwrs_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_o,
  input  logic [lwrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  input  logic [lwrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic [0:0]                       m_axis_tuser_o,
  input  logic                             m_axis_tlast_o,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_o,
  input  lwrs_pkg::width_t                 cfg_data_i
);
  import lwrs_pkg::*;

  // a stalled command stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output command dropped while stalled");

  // a stalled command keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // error commands stand alone and carry no rectangle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("error command not single or not cleared");

  // only the first-row command starts off column zero, and it is one row high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] && (m_axis_tdata_o[11:0] != '0) |->
      (m_axis_tdata_o[68:47] == 22'd1))
    else $error("offset rectangle taller than one row");

  // the first command of a write starts at source pixel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o ##1 m_axis_tvalid_o |->
      (m_axis_tdata_o[90:69] == '0))
    else $error("first command of a write has nonzero source offset");

endmodule

bind linear_write_to_rect_splitter lwrs_checker u_lwrs_checker (.*);
